### src/lpr_pkg.sv
// Shared constants and types for the LRU page replacement block.
// No dependencies; compile first.
package lpr_pkg;

  // Fixed widths of the channel fields and the configuration register
  localparam int PAGE_W  = 16;
  localparam int FIDX_W  = 4;
  localparam int FCNT_W  = 5;
  localparam int FAULT_W = 16;

  // Defaults for the top-level parameters
  localparam int FRAMES_DEF    = 16;
  localparam int PAGE_BITS_DEF = 16;

  localparam logic [FCNT_W-1:0] FCNT_RESET = 5'd16;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT
  } state_t;

endpackage

### src/lpr_if.sv
// Valid/ready channel interfaces for page references and replacement results.
// Depends on lpr_pkg for the field widths.
interface lpr_in_if;
  import lpr_pkg::*;
  logic              valid;
  logic              ready;
  logic [PAGE_W-1:0] page;

  modport source (output valid, output page, input ready);
  modport sink   (input valid, input page, output ready);
endinterface

interface lpr_out_if;
  import lpr_pkg::*;
  logic               valid;
  logic               ready;
  logic               hit;
  logic [FIDX_W-1:0]  frame_index;
  logic               evicted_valid;
  logic [PAGE_W-1:0]  evicted_page;
  logic [FAULT_W-1:0] fault_total;

  modport source (output valid, output hit, output frame_index, output evicted_valid,
                  output evicted_page, output fault_total, input ready);
  modport sink   (input valid, input hit, input frame_index, input evicted_valid,
                  input evicted_page, input fault_total, output ready);
endinterface

### src/lpr_cell.sv
// One page frame cell: holds page, valid flag and recency rank, merges the
// passing probe word with its own state and applies commit/flush commands.
module lpr_cell #(
  parameter int  FRAMES    = 16,
  parameter int  PAGE_BITS = 16,
  parameter int  IDX       = 0,
  parameter type probe_t   = logic,
  parameter type cmd_t     = logic
) (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   active,
  input  probe_t probe_i,
  output probe_t probe_o,
  input  cmd_t   cmd_i
);

  localparam int IW = $clog2(FRAMES);
  localparam logic [IW-1:0] MY_IDX   = IW'(IDX);
  localparam logic [IW-1:0] RANK_MAX = IW'(FRAMES - 1);

  logic [PAGE_BITS-1:0] page_r;
  logic                 valid_r;
  logic [IW-1:0]        rank_r;
  probe_t               probe_r;
  probe_t               probe_nxt;

  // Fold this frame into the running search
  always_comb begin
    probe_nxt = probe_i;
    if (probe_i.valid && active) begin
      if (!probe_i.hit_found && valid_r && page_r == probe_i.page) begin
        probe_nxt.hit_found = 1'b1;
        probe_nxt.hit_idx   = MY_IDX;
        probe_nxt.hit_rank  = rank_r;
      end
      if (!probe_i.empty_found && !valid_r) begin
        probe_nxt.empty_found = 1'b1;
        probe_nxt.empty_idx   = MY_IDX;
      end
      if (!probe_i.best_set || rank_r > probe_i.best_rank) begin
        probe_nxt.best_set  = 1'b1;
        probe_nxt.best_rank = rank_r;
        probe_nxt.best_idx  = MY_IDX;
        probe_nxt.best_page = page_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      probe_r <= '0;
    end else begin
      probe_r <= probe_nxt;
    end
  end

  assign probe_o = probe_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      rank_r  <= '0;
    end else if (cmd_i.flush) begin
      valid_r <= 1'b0;
      rank_r  <= '0;
    end else if (cmd_i.commit && active) begin
      if (cmd_i.slot == MY_IDX) begin
        rank_r <= '0;
        if (cmd_i.fault) begin
          valid_r <= 1'b1;
        end
      end else if (valid_r && (cmd_i.age_all || rank_r < cmd_i.limit) &&
                   rank_r != RANK_MAX) begin
        rank_r <= rank_r + 1'b1;
      end
    end
  end

  // Payload: only meaningful while valid_r is set
  always_ff @(posedge clk) begin
    if (cmd_i.commit && active && cmd_i.fault && cmd_i.slot == MY_IDX) begin
      page_r <= cmd_i.page;
    end
  end

endmodule

### src/lru_page_replacement.sv
// Top level of the LRU page replacement block: control sequencer, fault
// counter, result register and the chain of lpr_cell frames.
// Depends on lpr_pkg, lpr_if (lpr_in_if, lpr_out_if) and lpr_cell.

// Each input word carries a page number; each output word reports hit or
// fault, the frame that now holds the page, the page evicted (if any) and a
// saturating fault count. The frames sit in a chain of FRAMES cells; a probe
// word enters cell 0 when a reference is accepted and moves one cell per
// cycle, picking up the first matching frame, the first empty frame and the
// oldest frame (largest rank, lowest index on ties) as it goes. After the
// last cell, the commit state broadcasts the decision to all cells; the
// active cells update page, valid flag and rank together, and the result
// register is loaded. One reference is in flight at a time: after it is
// accepted it is launched, passes along the chain and is committed before
// the next reference can be accepted. The result register lets the next
// reference be accepted while a result waits; the commit stalls only if the
// previous result is still unread. Writing cfg_wdata empties all frames and
// clears ranks; the fault count is kept. A frame count of zero acts as one,
// and a count above FRAMES acts as FRAMES; frames past the count are never
// used.
module lru_page_replacement #(
  parameter int FRAMES    = lpr_pkg::FRAMES_DEF,
  parameter int PAGE_BITS = lpr_pkg::PAGE_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  lpr_in_if.sink                    in_if,
  lpr_out_if.source                 out_if,
  input  logic                      cfg_we,
  input  logic [lpr_pkg::FCNT_W-1:0] cfg_wdata
);

  import lpr_pkg::*;

  localparam int IW = $clog2(FRAMES);
  localparam int NW = $clog2(FRAMES + 1);

  typedef struct packed {
    logic                 valid;
    logic [PAGE_BITS-1:0] page;
    logic                 hit_found;
    logic [IW-1:0]        hit_idx;
    logic [IW-1:0]        hit_rank;
    logic                 empty_found;
    logic [IW-1:0]        empty_idx;
    logic                 best_set;
    logic [IW-1:0]        best_rank;
    logic [IW-1:0]        best_idx;
    logic [PAGE_BITS-1:0] best_page;
  } probe_t;

  typedef struct packed {
    logic                 flush;
    logic                 commit;
    logic                 fault;
    logic                 age_all;
    logic [IW-1:0]        slot;
    logic [IW-1:0]        limit;
    logic [PAGE_BITS-1:0] page;
  } cmd_t;

  state_t state_r, state_nxt;

  logic [FCNT_W-1:0]  frame_count_r;
  logic [NW-1:0]      n_eff;
  logic [FRAMES-1:0]  active;
  logic [FAULT_W-1:0] fault_r, fault_nxt;

  probe_t             chain [FRAMES+1];
  logic [FRAMES-1:0]  probe_vld;
  probe_t             fin_r;
  cmd_t               cmd;

  logic               accept;
  logic               capture;
  logic               commit_go;
  logic [IW-1:0]      slot;
  logic               evict;

  logic               out_valid_r;
  logic               out_hit_r;
  logic [FIDX_W-1:0]  out_frame_r;
  logic               out_evict_r;
  logic [PAGE_W-1:0]  out_evpage_r;

  // ---------------------------------------------------------------------
  // Frame count register: clamp to 1..FRAMES for the active mask
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_count_r <= FCNT_RESET;
    end else if (cfg_we) begin
      frame_count_r <= cfg_wdata;
    end
  end

  always_comb begin
    if (frame_count_r == '0) begin
      n_eff = NW'(1);
    end else if (32'(frame_count_r) > FRAMES) begin
      n_eff = NW'(FRAMES);
    end else begin
      n_eff = NW'(frame_count_r);
    end
  end

  // ---------------------------------------------------------------------
  // Sequencer: launch probe, wait for it to leave the chain, commit
  // ---------------------------------------------------------------------
  assign accept  = in_if.valid && in_if.ready;
  assign capture = (state_r == ST_SCAN) && chain[FRAMES].valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    in_if.ready = 1'b0;
    commit_go   = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_if.ready = 1'b1;
        if (in_if.valid) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (chain[FRAMES].valid) begin
          state_nxt = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        // Hold the decision until the result register is free
        commit_go = !out_valid_r || out_if.ready;
        if (commit_go) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Fresh probe word enters cell 0 on acceptance
  always_comb begin
    chain[0]       = '0;
    chain[0].valid = accept;
    chain[0].page  = PAGE_BITS'(32'(in_if.page));
  end

  // ---------------------------------------------------------------------
  // Cell chain
  // ---------------------------------------------------------------------
  for (genvar i = 0; i < FRAMES; i++) begin : g_cell
    assign active[i]    = 32'(n_eff) > i;
    assign probe_vld[i] = chain[i+1].valid;

    lpr_cell #(
      .FRAMES    (FRAMES),
      .PAGE_BITS (PAGE_BITS),
      .IDX       (i),
      .probe_t   (probe_t),
      .cmd_t     (cmd_t)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .active  (active[i]),
      .probe_i (chain[i]),
      .probe_o (chain[i+1]),
      .cmd_i   (cmd)
    );
  end

  // Hold the finished search word until commit
  always_ff @(posedge clk) begin
    if (capture) begin
      fin_r <= chain[FRAMES];
    end
  end

  // ---------------------------------------------------------------------
  // Decision: hit frame, else first empty frame, else oldest frame
  // ---------------------------------------------------------------------
  always_comb begin
    if (fin_r.hit_found) begin
      slot = fin_r.hit_idx;
    end else if (fin_r.empty_found) begin
      slot = fin_r.empty_idx;
    end else begin
      slot = fin_r.best_idx;
    end
    evict = !fin_r.hit_found && !fin_r.empty_found;

    cmd.flush   = cfg_we;
    cmd.commit  = commit_go;
    cmd.fault   = !fin_r.hit_found;
    cmd.age_all = !fin_r.hit_found;
    cmd.slot    = slot;
    cmd.limit   = fin_r.hit_rank;
    cmd.page    = fin_r.page;
  end

  // Saturating fault count, kept across frame count writes
  always_comb begin
    fault_nxt = fault_r;
    if (commit_go && !fin_r.hit_found && fault_r != '1) begin
      fault_nxt = fault_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fault_r <= '0;
    end else begin
      fault_r <= fault_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (commit_go) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit_go) begin
      out_hit_r    <= fin_r.hit_found;
      out_frame_r  <= FIDX_W'(32'(slot));
      out_evict_r  <= evict;
      out_evpage_r <= evict ? PAGE_W'(32'(fin_r.best_page)) : '0;
    end
  end

  assign out_if.valid         = out_valid_r;
  assign out_if.hit           = out_hit_r;
  assign out_if.frame_index   = out_frame_r;
  assign out_if.evicted_valid = out_evict_r;
  assign out_if.evicted_page  = out_evpage_r;
  assign out_if.fault_total   = fault_r;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_one_probe: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(probe_vld))
    else $error("more than one probe word in the cell chain");

  a_probe_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    chain[FRAMES].valid |-> state_r == ST_SCAN)
    else $error("probe left the chain outside the scan phase");

  a_hit_no_fault: assert property (@(posedge clk) disable iff (!rst_n)
    (commit_go && fin_r.hit_found) |=> fault_r == $past(fault_r))
    else $error("fault count moved on a hit");

  a_evict_on_fault: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_evict_r) |-> !out_hit_r)
    else $error("eviction reported on a hit");

  a_commit_empty_out: assert property (@(posedge clk) disable iff (!rst_n)
    commit_go |-> (!out_valid_r || out_if.ready))
    else $error("result register overwritten before it was taken");

endmodule

### tb/lru_page_replacement_tb.sv
// Self-checking testbench for lru_page_replacement: a queue-fed driver, a result
// monitor and an LRU predictor kept in step with the block's frame count.
// Depends on lpr_pkg, lpr_if (lpr_in_if, lpr_out_if) and the RTL under src.
module lru_page_replacement_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lpr_pkg::*;

  localparam int FRAMES       = FRAMES_DEF;
  localparam int LONG_HOLD    = 300;      // cycles the receiver holds off in one stretch
  localparam int LIMIT_CYCLES = 600000;   // watchdog, several times the slowest clean run

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  // One result word as the block should report it
  typedef struct packed {
    logic               hit;
    logic [FIDX_W-1:0]  frame_index;
    logic               evicted_valid;
    logic [PAGE_W-1:0]  evicted_page;
    logic [FAULT_W-1:0] fault_total;
  } lookup_result_t;

  logic              clk;
  logic              rst_n = 1'b0;
  logic              cfg_we = 1'b0;
  logic [FCNT_W-1:0] cfg_wdata = '0;

  lpr_in_if  in_ch ();
  lpr_out_if out_ch ();

  lru_page_replacement #(
    .FRAMES    (FRAMES),
    .PAGE_BITS (PAGE_BITS_DEF)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_ch),
    .out_if    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // Predictor state: a private copy of the frames, ranks, fault count and register
  logic [PAGE_W-1:0]  frame_page_m [FRAMES];
  bit                 frame_valid_m [FRAMES];
  logic [3:0]         age_rank_m [FRAMES];
  logic [FAULT_W-1:0] faults_m;
  logic [FCNT_W-1:0]  frame_count_m;

  logic [PAGE_W-1:0] refs_q [$];         // page references waiting for the driver
  lookup_result_t    lookups_q [$];      // predicted results, oldest first

  idle_mode_t idle_mode = IDLE_NONE;
  int         mismatches = 0;
  int         cycle_cnt = 0;
  int         hold_reqs = 0;             // bumped by the sequencer to ask for a long stall
  int         hold_seen = 0;
  int         hold_left = 0;
  logic [PAGE_W-1:0] pool_base;
  int                pool_size;
  logic [PAGE_W-1:0] last_page = '0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Watchdog: a stuck handshake or a lost word ends the run here.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt, lookups_q.size());
      $display("FAIL");
      $finish;
    end
  end

  // Zero reads as one frame, anything past FRAMES is clamped.
  function automatic int frames_in_use();
    int n;
    n = int'(frame_count_m);
    if (n == 0) n = 1;
    if (n > FRAMES) n = FRAMES;
    return n;
  endfunction

  function automatic void flush_model();
    for (int i = 0; i < FRAMES; i++) begin
      frame_page_m[i]  = '0;
      frame_valid_m[i] = 1'b0;
      age_rank_m[i]    = '0;
    end
  endfunction

  // Age every other valid frame whose rank is below lim (ranks stop at FRAMES-1),
  // then make the chosen frame the newest.
  function automatic void promote(input int n, input int chosen, input int lim);
    for (int i = 0; i < n; i++) begin
      if (i != chosen && frame_valid_m[i] && int'(age_rank_m[i]) < lim &&
          int'(age_rank_m[i]) < FRAMES - 1)
        age_rank_m[i] = age_rank_m[i] + 4'd1;
    end
    age_rank_m[chosen] = '0;
  endfunction

  // Look one page up in the predicted frames and update them as the block must.
  function automatic lookup_result_t lru_access(input logic [PAGE_W-1:0] page);
    lookup_result_t r;
    int  n;
    int  slot;
    int  oldest;
    bit  found;
    bit  empty;
    n      = frames_in_use();
    slot   = 0;
    found  = 1'b0;
    empty  = 1'b0;
    r      = '0;
    for (int i = 0; i < n; i++) begin
      if (!found && frame_valid_m[i] && frame_page_m[i] == page) begin
        slot  = i;
        found = 1'b1;
      end
    end
    if (found) begin
      promote(n, slot, int'(age_rank_m[slot]));
    end else begin
      for (int i = 0; i < n; i++) begin
        if (!empty && !frame_valid_m[i]) begin
          slot  = i;
          empty = 1'b1;
        end
      end
      if (!empty) begin
        // Largest rank loses its frame; the strict compare keeps the lowest index on ties.
        oldest = 0;
        slot   = 0;
        for (int i = 0; i < n; i++) begin
          if (int'(age_rank_m[i]) > oldest) begin
            oldest = int'(age_rank_m[i]);
            slot   = i;
          end
        end
        r.evicted_valid = 1'b1;
        r.evicted_page  = frame_page_m[slot];
      end
      frame_page_m[slot]  = page;
      frame_valid_m[slot] = 1'b1;
      promote(n, slot, 1 << 30);
      if (faults_m != '1) faults_m = faults_m + 1'b1;
    end
    r.hit         = found;
    r.frame_index = slot[FIDX_W-1:0];
    r.fault_total = faults_m;
    return r;
  endfunction

  task automatic note_mismatch(input string msg);
    mismatches++;
    $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want) note_mismatch($sformatf("%s got %h want %h", name, got, want));
  endtask

  // Driver: predict each word at its handshake, then offer the next one or go idle.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) lookups_q.push_back(lru_access(in_ch.page));
      if (!in_ch.valid || in_ch.ready) begin
        if (refs_q.size() > 0 &&
            $urandom_range(0, 99) >= (idle_mode == IDLE_SENDER ? 45 :
                                      idle_mode == IDLE_BOTH   ? 25 : 0)) begin
          in_ch.valid <= 1'b1;
          in_ch.page  <= refs_q.pop_front();
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each accepted result word against the oldest prediction and
  // decide ready for the next cycle (random stalls, or a long hold when asked).
  always @(posedge clk) begin
    lookup_result_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (lookups_q.size() == 0) begin
          note_mismatch("result word with nothing predicted");
        end else begin
          want = lookups_q.pop_front();
          check_field("hit", 16'(out_ch.hit), 16'(want.hit));
          check_field("frame_index", 16'(out_ch.frame_index), 16'(want.frame_index));
          check_field("evicted_valid", 16'(out_ch.evicted_valid), 16'(want.evicted_valid));
          check_field("evicted_page", out_ch.evicted_page, want.evicted_page);
          check_field("fault_total", out_ch.fault_total, want.fault_total);
        end
      end
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left    <= hold_left - 1;
      end else if (hold_reqs != hold_seen) begin
        hold_seen    <= hold_reqs;
        hold_left    <= LONG_HOLD;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= $urandom_range(0, 99) >= (idle_mode == IDLE_RECEIVER ? 45 :
                                                  idle_mode == IDLE_BOTH     ? 25 : 0);
      end
    end
  end

  // Block until every queued reference was taken and every result came back.
  task automatic wait_drained();
    do @(negedge clk);
    while (refs_q.size() != 0 || in_ch.valid || lookups_q.size() != 0);
  endtask

  // Write the frame count while idle; the block empties its frames on the write.
  task automatic write_frame_count(input logic [FCNT_W-1:0] value);
    wait_drained();
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we        <= 1'b0;
    frame_count_m  = value;
    flush_model();
    @(negedge clk);
  endtask

  // Mostly pages from a small pool so hits and evictions both happen; some repeats,
  // some extremes and some full-range noise to toggle every bit.
  function automatic logic [PAGE_W-1:0] next_page();
    int roll;
    logic [PAGE_W-1:0] p;
    roll = $urandom_range(0, 99);
    if (roll < 65)      p = pool_base + PAGE_W'($urandom_range(0, pool_size - 1));
    else if (roll < 75) p = last_page;
    else if (roll < 82) p = ($urandom_range(0, 1) != 0) ? '1 : '0;
    else                p = PAGE_W'($urandom);
    last_page = p;
    return p;
  endfunction

  // One random phase: set the count and the idling, send half, let the sender pause
  // until all results are back, then send the rest.
  task automatic run_phase(input logic [FCNT_W-1:0] count, input idle_mode_t mode,
                           input int n, input bit long_hold);
    write_frame_count(count);
    idle_mode = mode;
    pool_base = PAGE_W'($urandom);
    pool_size = $urandom_range(1, 2 * frames_in_use() + 3);
    for (int k = 0; k < n / 2; k++) refs_q.push_back(next_page());
    // Hold the receiver off while the sender keeps offering, so the input backs up.
    if (long_hold) hold_reqs++;
    wait_drained();
    pool_size = $urandom_range(1, frames_in_use() + 2);
    for (int k = n / 2; k < n; k++) refs_q.push_back(next_page());
  endtask

  initial begin
    frame_count_m = FCNT_RESET;
    faults_m      = '0;
    flush_model();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset count of 16: an empty frame holding page zero must not hit.
    refs_q.push_back(16'h0000);
    refs_q.push_back(16'h0000);
    refs_q.push_back(16'hFFFF);
    refs_q.push_back(16'hFFFF);
    refs_q.push_back(16'h0000);

    // Three frames: fill in order, evict the oldest, hits reorder the ranks.
    write_frame_count(5'd3);
    refs_q.push_back(16'h0000);
    refs_q.push_back(16'h0001);
    refs_q.push_back(16'h0002);
    refs_q.push_back(16'h0003);
    refs_q.push_back(16'h0001);
    refs_q.push_back(16'h0004);
    refs_q.push_back(16'h0003);
    refs_q.push_back(16'h0005);

    // Count zero acts as a single frame: every new page replaces the last.
    write_frame_count(5'd0);
    refs_q.push_back(16'h0007);
    refs_q.push_back(16'h0007);
    refs_q.push_back(16'h0008);
    refs_q.push_back(16'hFFFF);

    // Count of 31 clamps to all frames.
    write_frame_count(5'd31);
    refs_q.push_back(16'h8000);
    refs_q.push_back(16'h7FFF);
    refs_q.push_back(16'hAAAA);
    refs_q.push_back(16'h5555);
    refs_q.push_back(16'h8000);

    // Random phases across the count range and every idling pattern.
    run_phase(5'd16, IDLE_NONE,     160, 1'b1);
    run_phase(5'd1,  IDLE_SENDER,   150, 1'b0);
    run_phase(5'd0,  IDLE_RECEIVER, 150, 1'b0);
    run_phase(5'd31, IDLE_BOTH,     170, 1'b0);
    run_phase(5'd2,  IDLE_NONE,     150, 1'b0);
    run_phase(5'd17, IDLE_SENDER,   170, 1'b0);
    run_phase(5'd8,  IDLE_RECEIVER, 160, 1'b1);
    run_phase(5'd5,  IDLE_BOTH,     150, 1'b0);
    run_phase(5'd16, IDLE_RECEIVER, 170, 1'b0);
    run_phase(5'($urandom_range(1, 16)), IDLE_SENDER, 150, 1'b0);
    run_phase(5'd4,  IDLE_NONE,     150, 1'b0);

    wait_drained();
    // Leave room for any stray word after the last expected one.
    repeat (FRAMES + 4) @(posedge clk);
    if (lookups_q.size() != 0)
      note_mismatch($sformatf("%0d predicted results never arrived", lookups_q.size()));
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
